// ===== hw/rtl/bir_pkg.sv =====
package bir_pkg;

    localparam int POS_W     = 12;
    localparam int PIX_W     = 8;
    localparam int SRC_W     = 9;
    localparam int TGT_W     = 13;
    localparam int CFG_W     = 13;
    localparam int TGT_MAX   = 4096;
    localparam int TGT_RST   = 224;
    localparam int QUO_W     = 18;
    localparam int REM_W     = 13;
    localparam int PROD_W    = 22;
    localparam int BASE_W    = 11;
    localparam int WGT_W     = 28;
    localparam int W2D_W     = 2 * WGT_W;
    localparam int ACC_W     = 64;
    localparam int CNT_W     = 5;
    localparam int DIV_STEPS = QUO_W;
    localparam int TAPS      = 16;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TGT_WIDTH  = 2'd2;
    localparam logic [1:0] REG_TGT_HEIGHT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_X,
        ST_SAVE_X,
        ST_DIV_Y,
        ST_SAVE_Y,
        ST_WGT_SQ,
        ST_WGT_CUBE,
        ST_WGT_SUM,
        ST_TAP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       store;
        logic       load;
        logic       div_load;
        logic       div_sel_y;
        logic       div_step;
        logic       save_x;
        logic       save_y;
        logic       wgt_sq;
        logic       wgt_cube;
        logic       wgt_sum;
        logic       tap_en;
        logic [3:0] tap;
        logic       out_load;
    } bir_cmd_t;

    typedef struct packed {
        logic oor;
    } bir_sts_t;

endpackage

// ===== hw/rtl/bir_ctrl.sv =====
module bir_ctrl
    import bir_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_command,
    output logic     m_valid,
    input  logic     m_ready,
    input  bir_sts_t sts,
    output bir_cmd_t cmd
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_command == CMD_COMPUTE) state_next = ST_CHECK;
            end
            ST_CHECK:    state_next = sts.oor ? ST_FINISH : ST_DIV_X;
            ST_DIV_X: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_SAVE_X;
            end
            ST_SAVE_X:   state_next = ST_DIV_Y;
            ST_DIV_Y: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_SAVE_Y;
            end
            ST_SAVE_Y:   state_next = ST_WGT_SQ;
            ST_WGT_SQ:   state_next = ST_WGT_CUBE;
            ST_WGT_CUBE: state_next = ST_WGT_SUM;
            ST_WGT_SUM:  state_next = ST_TAP;
            ST_TAP: begin
                if (cnt_reg == CNT_W'(TAPS - 1)) state_next = ST_DRAIN;
            end
            ST_DRAIN:    state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.tap      = cnt_reg[3:0];
        cnt_next     = '0;
        m_valid_next = m_valid_reg;
        if (m_ready) m_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.store = s_valid && s_command == CMD_STORE;
                cmd.load  = s_valid && s_command == CMD_COMPUTE;
            end
            ST_CHECK:    cmd.div_load = !sts.oor;
            ST_DIV_X, ST_DIV_Y: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) cnt_next = '0;
            end
            ST_SAVE_X: begin
                cmd.save_x    = 1'b1;
                cmd.div_load  = 1'b1;
                cmd.div_sel_y = 1'b1;
            end
            ST_SAVE_Y:   cmd.save_y   = 1'b1;
            ST_WGT_SQ:   cmd.wgt_sq   = 1'b1;
            ST_WGT_CUBE: cmd.wgt_cube = 1'b1;
            ST_WGT_SUM:  cmd.wgt_sum  = 1'b1;
            ST_TAP: begin
                cmd.tap_en = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TAPS - 1)) cnt_next = '0;
            end
            ST_DRAIN: ;
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/bir_datapath.sv =====
module bir_datapath
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int CHANNELS   = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic [POS_W-1:0] s_pos_x,
    input  logic [POS_W-1:0] s_pos_y,
    input  logic [PIX_W-1:0] s_in_red,
    input  logic [PIX_W-1:0] s_in_green,
    input  logic [PIX_W-1:0] s_in_blue,
    input  bir_cmd_t         cmd,
    output bir_sts_t         sts,
    output logic [PIX_W-1:0] m_out_red,
    output logic [PIX_W-1:0] m_out_green,
    output logic [PIX_W-1:0] m_out_blue,
    output logic             m_out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SRC_W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int SRC_H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    // configuration
    logic [SRC_W-1:0] src_w_reg, src_h_reg;
    logic [TGT_W-1:0] tgt_w_reg, tgt_h_reg;
    logic [SRC_W-1:0] cfg_src_w, cfg_src_h;
    logic [TGT_W-1:0] cfg_tgt;

    function automatic logic [SRC_W-1:0] sat_src(input logic [SRC_W-1:0] v, input int hi);
        logic [SRC_W-1:0] r;
        r = v;
        if (v == '0) r = SRC_W'(1);
        else if (TGT_W'(v) > TGT_W'(hi)) r = SRC_W'(hi);
        return r;
    endfunction

    always_comb begin
        cfg_src_w = sat_src(cfg_wr_data[SRC_W-1:0], MAX_WIDTH);
        cfg_src_h = sat_src(cfg_wr_data[SRC_W-1:0], MAX_HEIGHT);
        cfg_tgt   = cfg_wr_data[TGT_W-1:0];
        if (cfg_tgt == '0) cfg_tgt = TGT_W'(1);
        else if (cfg_tgt > TGT_W'(TGT_MAX)) cfg_tgt = TGT_W'(TGT_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= SRC_W'(SRC_W_RST);
            src_h_reg <= SRC_W'(SRC_H_RST);
            tgt_w_reg <= TGT_W'(TGT_RST);
            tgt_h_reg <= TGT_W'(TGT_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_w_reg <= cfg_src_w;
                REG_SRC_HEIGHT: src_h_reg <= cfg_src_h;
                REG_TGT_WIDTH:  tgt_w_reg <= cfg_tgt;
                REG_TGT_HEIGHT: tgt_h_reg <= cfg_tgt;
                default: ;
            endcase
        end
    end

    // frame store
    logic [3*PIX_W-1:0] mem [DEPTH];
    logic [3*PIX_W-1:0] rd_data_reg;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic               wr_en;

    assign wr_en   = cmd.store && ({1'b0, s_pos_x} < TGT_W'(src_w_reg))
                     && ({1'b0, s_pos_y} < TGT_W'(src_h_reg));
    assign wr_addr = AW'(s_pos_y) * AW'(MAX_WIDTH) + AW'(s_pos_x);

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= {s_in_red, s_in_green, s_in_blue};
        if (cmd.tap_en) rd_data_reg <= mem[rd_addr];
    end

    // captured destination coordinate
    logic [POS_W-1:0] pos_x_reg, pos_y_reg;
    logic             oor;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_x_reg <= s_pos_x;
            pos_y_reg <= s_pos_y;
        end
    end

    assign oor     = ({1'b0, pos_x_reg} >= tgt_w_reg) || ({1'b0, pos_y_reg} >= tgt_h_reg);
    assign sts.oor = oor;

    // position divider: q = floor(128*(2x+1)*src / dst), one quotient bit per cycle
    logic [POS_W-1:0]  div_pos;
    logic [SRC_W-1:0]  div_src;
    logic [TGT_W-1:0]  div_dst;
    logic [PROD_W-1:0] div_prod;
    logic [PROD_W+6:0] div_dvd;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  dvd_reg, quo_reg;
    logic [TGT_W-1:0]  dsr_reg;
    logic [REM_W:0]    trial;
    logic              q_bit;

    assign div_pos  = cmd.div_sel_y ? pos_y_reg : pos_x_reg;
    assign div_src  = cmd.div_sel_y ? src_h_reg : src_w_reg;
    assign div_dst  = cmd.div_sel_y ? tgt_h_reg : tgt_w_reg;
    assign div_prod = PROD_W'({div_pos, 1'b1}) * PROD_W'(div_src);
    assign div_dvd  = {div_prod, 7'b0};
    assign trial    = {rem_reg, dvd_reg[QUO_W-1]};
    assign q_bit    = trial >= (REM_W+1)'(dsr_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= REM_W'(div_dvd[PROD_W+6:QUO_W]);
            dvd_reg <= div_dvd[QUO_W-1:0];
            dsr_reg <= div_dst;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? REM_W'(trial - (REM_W+1)'(dsr_reg)) : REM_W'(trial);
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], q_bit};
        end
    end

    // position = q - 128: low byte is the fraction, the rest the base tap
    logic signed [QUO_W:0]    pos_full;
    logic        [7:0]        fx_reg, fy_reg;
    logic signed [BASE_W-1:0] bx_reg, by_reg;

    assign pos_full = $signed({1'b0, quo_reg}) - $signed((QUO_W+1)'(128));

    always_ff @(posedge aclk) begin
        if (cmd.save_x) begin
            fx_reg <= pos_full[7:0];
            bx_reg <= pos_full[QUO_W:8];
        end
        if (cmd.save_y) begin
            fy_reg <= pos_full[7:0];
            by_reg <= pos_full[QUO_W:8];
        end
    end

    // Catmull-Rom weights, scaled by 2^25
    logic        [15:0]      a2x_reg, a2y_reg;
    logic        [23:0]      a3x_reg, a3y_reg;
    logic signed [WGT_W-1:0] wx_reg [4];
    logic signed [WGT_W-1:0] wy_reg [4];

    function automatic logic signed [WGT_W-1:0] calc_wgt(input logic [7:0] f,
                                                         input logic [15:0] a2,
                                                         input logic [23:0] a3,
                                                         input logic [1:0] k);
        logic signed [31:0] sa, sa2, sa3, r;
        sa  = $signed(32'(f));
        sa2 = $signed(32'(a2));
        sa3 = $signed(32'(a3));
        unique case (k)
            2'd0:    r = -sa3 + 512 * sa2 - 65536 * sa;
            2'd1:    r = 3 * sa3 - 1280 * sa2 + 32'sd33554432;
            2'd2:    r = -3 * sa3 + 1024 * sa2 + 65536 * sa;
            default: r = sa3 - 256 * sa2;
        endcase
        return r[WGT_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.wgt_sq) begin
            a2x_reg <= 16'(fx_reg) * 16'(fx_reg);
            a2y_reg <= 16'(fy_reg) * 16'(fy_reg);
        end
        if (cmd.wgt_cube) begin
            a3x_reg <= 24'(a2x_reg) * 24'(fx_reg);
            a3y_reg <= 24'(a2y_reg) * 24'(fy_reg);
        end
        if (cmd.wgt_sum) begin
            for (int k = 0; k < 4; k++) begin
                wx_reg[k] <= calc_wgt(fx_reg, a2x_reg, a3x_reg, 2'(k));
                wy_reg[k] <= calc_wgt(fy_reg, a2y_reg, a3y_reg, 2'(k));
            end
        end
    end

    // tap coordinates, clamped to the source edges
    function automatic logic [SRC_W-1:0] clamp_tap(input logic signed [BASE_W-1:0] b,
                                                   input logic [1:0] n,
                                                   input logic [SRC_W-1:0] lim);
        logic signed [POS_W-1:0] v;
        logic [SRC_W-1:0]        r;
        v = POS_W'(b) + $signed(POS_W'(n)) - $signed(POS_W'(1));
        r = v[SRC_W-1:0];
        if (v < 0) r = '0;
        else if (v > $signed(POS_W'(lim - 1'b1))) r = lim - 1'b1;
        return r;
    endfunction

    logic [SRC_W-1:0] tap_x, tap_y;

    assign tap_x   = clamp_tap(bx_reg, cmd.tap[1:0], src_w_reg);
    assign tap_y   = clamp_tap(by_reg, cmd.tap[3:2], src_h_reg);
    assign rd_addr = AW'(tap_y) * AW'(MAX_WIDTH) + AW'(tap_x);

    // multiply-accumulate: the 2D weight meets its pixel in the cycle after the read
    logic signed [W2D_W-1:0] w2d_reg;
    logic                    mac_en_reg;
    logic signed [ACC_W-1:0] acc_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) mac_en_reg <= 1'b0;
        else          mac_en_reg <= cmd.tap_en;
    end

    always_ff @(posedge aclk) begin
        if (cmd.tap_en) w2d_reg <= wx_reg[cmd.tap[1:0]] * wy_reg[cmd.tap[3:2]];
    end

    for (genvar c = 0; c < 3; c++) begin : g_mac
        logic        [PIX_W-1:0]  pix;
        logic signed [W2D_W+8:0]  prod;
        assign pix  = rd_data_reg[3*PIX_W-1-PIX_W*c -: PIX_W];
        assign prod = w2d_reg * $signed({1'b0, pix});
        always_ff @(posedge aclk) begin
            if (cmd.wgt_sum) acc_reg[c] <= '0;
            else if (mac_en_reg) acc_reg[c] <= acc_reg[c] + $signed(prod[ACC_W-1:0]);
        end
    end

    // round half up at 2^50, clamp to 0..255
    function automatic logic [PIX_W-1:0] round_pix(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] t;
        logic [PIX_W-1:0] r;
        t = ACC_W'(a) + (ACC_W'(1) << 49);
        r = '0;
        if (a > 0) begin
            if (t[ACC_W-1:50] > (ACC_W-50)'(255)) r = '1;
            else r = t[57:50];
        end
        return r;
    endfunction

    logic [PIX_W-1:0] out_r_reg, out_g_reg, out_b_reg;
    logic             out_oor_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_oor_reg <= oor;
            out_r_reg   <= (oor || CHANNELS < 1) ? '0 : round_pix(acc_reg[0]);
            out_g_reg   <= (oor || CHANNELS < 2) ? '0 : round_pix(acc_reg[1]);
            out_b_reg   <= (oor || CHANNELS < 3) ? '0 : round_pix(acc_reg[2]);
        end
    end

    assign m_out_red      = out_r_reg;
    assign m_out_green    = out_g_reg;
    assign m_out_blue     = out_b_reg;
    assign m_out_of_range = out_oor_reg;

endmodule

// ===== hw/rtl/bicubic_image_resampler_core.sv =====
// Channel   Handshake          Payload
// s_        s_valid/s_ready    s_command, s_pos_x, s_pos_y, s_in_red/green/blue
// m_        m_valid/m_ready    m_out_red/green/blue, m_out_of_range
// cfg_      cfg_wr_en          cfg_index, cfg_wr_data
//
// A store in range is written at its transfer, and s_ready stays high. A compute
// runs two position divisions (one quotient bit per cycle) and three weight steps, then
// reads sixteen taps one per cycle from the frame store into a shared multiply-accumulate
// and raises m_valid; s_ready returns in the same cycle as m_valid.
// An out-of-range compute goes from the range check straight to the step raising m_valid.
// Reset is synchronous, active low; the frame store is not cleared.
// A result waits in the output register while the next item is taken; a full,
// stalled output register holds the next result back only at its final step.
module bicubic_image_resampler_core
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int CHANNELS   = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_command,
    input  logic [POS_W-1:0] s_pos_x,
    input  logic [POS_W-1:0] s_pos_y,
    input  logic [PIX_W-1:0] s_in_red,
    input  logic [PIX_W-1:0] s_in_green,
    input  logic [PIX_W-1:0] s_in_blue,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_out_red,
    output logic [PIX_W-1:0] m_out_green,
    output logic [PIX_W-1:0] m_out_blue,
    output logic             m_out_of_range
);

    bir_cmd_t cmd;
    bir_sts_t sts;

    bir_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bir_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CHANNELS   (CHANNELS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_in_red       (s_in_red),
        .s_in_green     (s_in_green),
        .s_in_blue      (s_in_blue),
        .cmd            (cmd),
        .sts            (sts),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_out_of_range (m_out_of_range)
    );

endmodule

// ===== bench/bicubic_image_resampler_core_tb.sv =====
`timescale 1ns / 100ps

module bicubic_image_resampler_core_tb;
    import bir_pkg::*;

    localparam int STORE_W   = 256;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 80;

    typedef struct {
        logic             cmd;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } pix_cmd_t;

    typedef struct {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic             oor;
    } pix_out_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic             s_command;
    logic [POS_W-1:0] s_pos_x;
    logic [POS_W-1:0] s_pos_y;
    logic [PIX_W-1:0] s_in_red;
    logic [PIX_W-1:0] s_in_green;
    logic [PIX_W-1:0] s_in_blue;
    logic             m_valid;
    logic             m_ready;
    logic [PIX_W-1:0] m_out_red;
    logic [PIX_W-1:0] m_out_green;
    logic [PIX_W-1:0] m_out_blue;
    logic             m_out_of_range;

    bicubic_image_resampler_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_in_red       (s_in_red),
        .s_in_green     (s_in_green),
        .s_in_blue      (s_in_blue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_out_of_range (m_out_of_range)
    );

    pix_cmd_t    pending_cmds[$];
    pix_out_t    expected_pixels[$];
    logic [23:0] frame_copy[STORE_W*STORE_W];
    int          src_w, src_h, tgt_w, tgt_h;
    int          n_fail;
    int          n_sent;
    int          quiet_cycles;
    logic        in_xfer;
    pix_cmd_t    next_cmd;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int clip(input longint v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic longint clamp_tap(input longint v, input int n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    // Pixel-centre mapping: floor of num/(2*dst) with num scaled by 256, split into tap and fraction.
    function automatic void map_coord(input longint x, input longint src, input longint dst,
                                      output longint base, output longint frac);
        longint num, d, q;
        num = ((2 * x + 1) * src - dst) * 256;
        d = 2 * dst;
        if (num >= 0) q = num / d;
        else q = -((-num + d - 1) / d);
        frac = q & 255;
        base = (q - frac) / 256;
    endfunction

    function automatic void cr_weights(input longint f, output longint w[4]);
        longint f2, f3;
        f2 = f * f;
        f3 = f2 * f;
        w[0] = -f3 + 512 * f2 - 65536 * f;
        w[1] = 3 * f3 - 1280 * f2 + (longint'(1) << 25);
        w[2] = -3 * f3 + 1024 * f2 + 65536 * f;
        w[3] = f3 - 256 * f2;
    endfunction

    function automatic pix_out_t resample_pixel(input int px, input int py);
        pix_out_t res;
        longint bx, by, fx, fy, acc, row, sx, sy, v;
        longint wx[4];
        longint wy[4];
        int sh;
        res = '{r: '0, g: '0, b: '0, oor: 1'b0};
        if (px >= tgt_w || py >= tgt_h) begin
            res.oor = 1'b1;
            return res;
        end
        map_coord(px, src_w, tgt_w, bx, fx);
        map_coord(py, src_h, tgt_h, by, fy);
        cr_weights(fx, wx);
        cr_weights(fy, wy);
        for (int c = 0; c < 3; c++) begin
            sh = 16 - 8 * c;
            acc = 0;
            for (int m = 0; m < 4; m++) begin
                sy = clamp_tap(by + m - 1, src_h);
                row = 0;
                for (int n = 0; n < 4; n++) begin
                    sx = clamp_tap(bx + n - 1, src_w);
                    row += wx[n] * longint'((frame_copy[sy * STORE_W + sx] >> sh) & 8'hFF);
                end
                acc += wy[m] * row;
            end
            v = 0;
            if (acc > 0) begin
                v = (acc + (longint'(1) << 49)) >>> 50;
                if (v > 255) v = 255;
            end
            case (c)
                0: res.r = v[7:0];
                1: res.g = v[7:0];
                default: res.b = v[7:0];
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        n_fail++;
    endtask

    // Model the block at each transfer.
    always @(posedge aclk) begin
        pix_out_t want;
        if (!aresetn) begin
            in_xfer <= 1'b0;
            src_w = 256; src_h = 256; tgt_w = TGT_RST; tgt_h = TGT_RST;
        end else begin
            in_xfer <= s_valid && s_ready;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_w = clip(cfg_wr_data[SRC_W-1:0], STORE_W);
                    REG_SRC_HEIGHT: src_h = clip(cfg_wr_data[SRC_W-1:0], STORE_W);
                    REG_TGT_WIDTH:  tgt_w = clip(cfg_wr_data, TGT_MAX);
                    default:        tgt_h = clip(cfg_wr_data, TGT_MAX);
                endcase
            end
            if (s_valid && s_ready) begin
                n_sent++;
                if (s_command == CMD_STORE) begin
                    if (s_pos_x < src_w && s_pos_y < src_h)
                        frame_copy[s_pos_y * STORE_W + s_pos_x] = {s_in_red, s_in_green, s_in_blue};
                end else begin
                    expected_pixels.push_back(resample_pixel(s_pos_x, s_pos_y));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("results pending", 1, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_out_red !== want.r) report_mismatch("red", m_out_red, want.r);
                    if (m_out_green !== want.g) report_mismatch("green", m_out_green, want.g);
                    if (m_out_blue !== want.b) report_mismatch("blue", m_out_blue, want.b);
                    if (m_out_of_range !== want.oor)
                        report_mismatch("out_of_range", m_out_of_range, want.oor);
                end
            end
        end
    end

    // Drive at the falling edge; idle rates follow the progress of the run.
    always @(negedge aclk) begin
        int s_idle, m_idle;
        if (n_sent < 210) begin
            s_idle = 36; m_idle = 58;
        end else if (n_sent < 420) begin
            s_idle = 58; m_idle = 36;
        end else begin
            s_idle = 0; m_idle = 0;
        end
        if (aresetn) begin
            if (!s_valid || in_xfer) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= s_idle) begin
                    next_cmd = pending_cmds.pop_front();
                    s_valid    <= 1'b1;
                    s_command  <= next_cmd.cmd;
                    s_pos_x    <= next_cmd.x;
                    s_pos_y    <= next_cmd.y;
                    s_in_red   <= next_cmd.r;
                    s_in_green <= next_cmd.g;
                    s_in_blue  <= next_cmd.b;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= m_idle);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("bicubic_image_resampler_core test failed");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] rand_pix();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_store(input int x, input int y);
        pending_cmds.push_back('{cmd: CMD_STORE, x: POS_W'(x), y: POS_W'(y),
                                 r: rand_pix(), g: rand_pix(), b: rand_pix()});
    endtask

    task automatic push_compute(input int x, input int y);
        pending_cmds.push_back('{cmd: CMD_COMPUTE, x: POS_W'(x), y: POS_W'(y),
                                 r: PIX_W'($urandom), g: PIX_W'($urandom),
                                 b: PIX_W'($urandom)});
    endtask

    // Hold until every transfer is done and every result is back.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_pixels.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Write all registers, then fill the whole source image so no read hits an empty entry.
    task automatic start_phase(input int sw, input int sh, input int tw, input int th);
        int raw[4];
        logic [1:0] regs[4];
        int ew, eh;
        raw = '{sw, sh, tw, th};
        regs = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_TGT_WIDTH, REG_TGT_HEIGHT};
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_index   <= regs[i];
            cfg_wr_data <= CFG_W'(raw[i]);
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        ew = src_w;
        eh = src_h;
        for (int y = 0; y < eh; y++)
            for (int x = 0; x < ew; x++)
                push_store(x, y);
    endtask

    task automatic random_items(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                push_compute($urandom_range(0, tgt_w - 1), $urandom_range(0, tgt_h - 1));
            else if (pick < 83)
                push_store($urandom_range(0, src_w - 1), $urandom_range(0, src_h - 1));
            else if (pick < 90)
                push_store($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                push_compute($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_command   = CMD_STORE;
        s_pos_x     = '0;
        s_pos_y     = '0;
        s_in_red    = '0;
        s_in_green  = '0;
        s_in_blue   = '0;
        m_ready     = 1'b0;
        in_xfer     = 1'b0;
        n_fail      = 0;
        n_sent      = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset sizes: only out-of-range samples, since the store is still empty.
        push_compute(TGT_RST, 0);
        push_compute(0, TGT_RST);
        push_compute(4095, 4095);

        start_phase(4, 4, 8, 8);
        push_compute(0, 0);
        push_compute(7, 7);
        push_compute(0, 7);
        push_compute(7, 0);
        push_compute(8, 0);
        push_compute(0, 8);
        push_store(4, 0);
        push_store(0, 4);
        push_store(4095, 4095);
        push_compute(3, 3);
        random_items(40);

        // Zero saturates to one.
        start_phase(0, 0, 0, 0);
        push_compute(0, 0);
        push_compute(1, 0);
        push_compute(0, 1);
        random_items(20);

        // Over-range values saturate to the maximum.
        start_phase(511, 1, 8191, 3);
        push_compute(4095, 2);
        push_compute(0, 0);
        random_items(30);

        start_phase(1, 6, 1, 4096);
        push_compute(0, 4095);
        push_compute(0, 0);
        random_items(30);

        start_phase(7, 5, 3, 2);
        random_items(30);

        start_phase(8, 6, 37, 29);
        random_items(30);

        start_phase(5, 9, 4096, 4096);
        random_items(30);

        wait_drained();
        if (n_fail == 0)
            $display("bicubic_image_resampler_core test passed");
        else
            $display("bicubic_image_resampler_core test failed");
        $finish;
    end

endmodule

// ===== bicubic_image_resampler_core.f =====
hw/rtl/bir_pkg.sv
hw/rtl/bir_ctrl.sv
hw/rtl/bir_datapath.sv
hw/rtl/bicubic_image_resampler_core.sv
bench/bicubic_image_resampler_core_tb.sv
